FILE: design/pnjl_pkg.sv
// ----------------------------------------------------------------------------
// pnjl_pkg
// shared constants and types for the pn-junction voltage limiter
// ----------------------------------------------------------------------------
package pnjl_pkg;

  // fraction bits of the internal logarithm
  localparam int LOG_FRAC = 30;
  // ln 2 in q.30
  localparam int LN2_Q30  = 744261118;
  // field widths of thermal and critical voltage
  localparam int VT_W     = 20;
  localparam int VC_W     = 31;
  // width of the leading-one position
  localparam int EXP_W    = 8;
  // width of the signed q.30 log term
  localparam int TERM_W   = 40;

  typedef logic [1:0] mode_t;

  localparam mode_t MODE_PASS = 2'd0;
  localparam mode_t MODE_UP   = 2'd1;
  localparam mode_t MODE_DOWN = 2'd2;
  localparam mode_t MODE_ABS  = 2'd3;

endpackage

FILE: design/pnjl_div.sv
// ----------------------------------------------------------------------------
// pnjl_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module pnjl_div #(
  parameter int NW = 49,
  parameter int SW = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_v,
  input  logic [NW-1:0]            num,
  input  logic [pnjl_pkg::VT_W-1:0] den,
  input  logic [SW-1:0]            side_i,
  output logic                     out_v,
  output logic [NW-1:0]            quo,
  output logic [SW-1:0]            side_o
);
  import pnjl_pkg::*;

  logic            v_r    [NW];
  logic [VT_W-1:0] rem_r  [NW];
  logic [NW-1:0]   nq_r   [NW];
  logic [VT_W-1:0] den_r  [NW];
  logic [SW-1:0]   side_r [NW];

  for (genvar i = 0; i < NW; i++) begin : g_stg
    logic            v_src;
    logic [VT_W-1:0] rem_src;
    logic [NW-1:0]   nq_src;
    logic [VT_W-1:0] den_src;
    logic [SW-1:0]   side_src;
    logic [VT_W:0]   trial;
    logic            ge;

    if (i == 0) begin : g_first
      assign v_src    = in_v;
      assign rem_src  = '0;
      assign nq_src   = num;
      assign den_src  = den;
      assign side_src = side_i;
    end else begin : g_next
      assign v_src    = v_r[i-1];
      assign rem_src  = rem_r[i-1];
      assign nq_src   = nq_r[i-1];
      assign den_src  = den_r[i-1];
      assign side_src = side_r[i-1];
    end

    // shift in the next dividend bit, subtract where it fits
    assign trial = {rem_src, nq_src[NW-1]};
    assign ge    = trial >= {1'b0, den_src};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else begin
        v_r[i] <= v_src;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[i]  <= ge ? VT_W'(trial - {1'b0, den_src}) : trial[VT_W-1:0];
      nq_r[i]   <= {nq_src[NW-2:0], ge};
      den_r[i]  <= den_src;
      side_r[i] <= side_src;
    end
  end

  assign out_v  = v_r[NW-1];
  assign quo    = nq_r[NW-1];
  assign side_o = side_r[NW-1];

endmodule

FILE: design/pnjl_log.sv
// ----------------------------------------------------------------------------
// pnjl_log
// pipelined natural logarithm, one squaring step per stage
// ----------------------------------------------------------------------------
module pnjl_log #(
  parameter int XW        = 50,
  parameter int FRAC_BITS = 16,
  parameter int SW        = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_v,
  input  logic [XW-1:0]                     x,
  input  logic [SW-1:0]                     side_i,
  output logic                              out_v,
  output logic signed [pnjl_pkg::TERM_W-1:0] ln,
  output logic [SW-1:0]                     side_o
);
  import pnjl_pkg::*;

  localparam logic signed [LOG_FRAC:0] LN2_S = (LOG_FRAC+1)'(LN2_Q30);
  localparam logic [LOG_FRAC-1:0]      LN2_U = LOG_FRAC'(LN2_Q30);

  // leading-one search
  logic [EXP_W-1:0] p_nxt;
  logic             a_v_r;
  logic [XW-1:0]    a_x_r;
  logic [EXP_W-1:0] a_p_r;
  logic [SW-1:0]    a_side_r;

  always_comb begin
    p_nxt = '0;
    for (int k = 0; k < XW; k++) begin
      if (x[k]) begin
        p_nxt = EXP_W'(k);
      end
    end
  end

  // normalise mantissa into [1, 2) in q.30
  logic [XW+LOG_FRAC-1:0] wide;
  logic                   b_v_r;
  logic [LOG_FRAC:0]      b_m_r;
  logic [EXP_W-1:0]       b_p_r;
  logic [SW-1:0]          b_side_r;

  always_comb begin
    if (a_p_r > EXP_W'(LOG_FRAC)) begin
      wide = {{LOG_FRAC{1'b0}}, a_x_r} >> (a_p_r - EXP_W'(LOG_FRAC));
    end else begin
      wide = {{LOG_FRAC{1'b0}}, a_x_r} << (EXP_W'(LOG_FRAC) - a_p_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
    end else begin
      a_v_r <= in_v;
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    a_x_r    <= x;
    a_p_r    <= p_nxt;
    a_side_r <= side_i;
    b_m_r    <= wide[LOG_FRAC:0];
    b_p_r    <= a_p_r;
    b_side_r <= a_side_r;
  end

  // fraction bits by repeated squaring
  logic                it_v_r    [LOG_FRAC];
  logic [LOG_FRAC:0]   it_m_r    [LOG_FRAC];
  logic [LOG_FRAC-1:0] it_f_r    [LOG_FRAC];
  logic [EXP_W-1:0]    it_p_r    [LOG_FRAC];
  logic [SW-1:0]       it_side_r [LOG_FRAC];

  for (genvar i = 0; i < LOG_FRAC; i++) begin : g_sq
    logic                    v_src;
    logic [LOG_FRAC:0]       m_src;
    logic [LOG_FRAC-1:0]     f_src;
    logic [EXP_W-1:0]        p_src;
    logic [SW-1:0]           side_src;
    logic [2*LOG_FRAC+1:0]   sq;
    logic [LOG_FRAC+1:0]     t;

    if (i == 0) begin : g_first
      assign v_src    = b_v_r;
      assign m_src    = b_m_r;
      assign f_src    = '0;
      assign p_src    = b_p_r;
      assign side_src = b_side_r;
    end else begin : g_next
      assign v_src    = it_v_r[i-1];
      assign m_src    = it_m_r[i-1];
      assign f_src    = it_f_r[i-1];
      assign p_src    = it_p_r[i-1];
      assign side_src = it_side_r[i-1];
    end

    assign sq = m_src * m_src;
    assign t  = sq[2*LOG_FRAC+1:LOG_FRAC];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        it_v_r[i] <= 1'b0;
      end else begin
        it_v_r[i] <= v_src;
      end
    end

    always_ff @(posedge clk) begin
      it_m_r[i]    <= t[LOG_FRAC+1] ? t[LOG_FRAC+1:1] : t[LOG_FRAC:0];
      it_f_r[i]    <= {f_src[LOG_FRAC-2:0], t[LOG_FRAC+1]};
      it_p_r[i]    <= p_src;
      it_side_r[i] <= side_src;
    end
  end

  // scale by ln 2 and add the integer part
  logic [2*LOG_FRAC-1:0]            fprod;
  logic signed [EXP_W:0]            ps;
  logic signed [EXP_W+LOG_FRAC+1:0] pl_full;
  logic                             c_v_r;
  logic [LOG_FRAC-1:0]              c_fp_r;
  logic signed [TERM_W-1:0]         c_pl_r;
  logic [SW-1:0]                    c_side_r;
  logic                             d_v_r;
  logic signed [TERM_W-1:0]         d_ln_r;
  logic [SW-1:0]                    d_side_r;

  assign fprod   = it_f_r[LOG_FRAC-1] * LN2_U;
  assign ps      = signed'({1'b0, it_p_r[LOG_FRAC-1]}) - (EXP_W+1)'(FRAC_BITS);
  assign pl_full = ps * LN2_S;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
      d_v_r <= 1'b0;
    end else begin
      c_v_r <= it_v_r[LOG_FRAC-1];
      d_v_r <= c_v_r;
    end
  end

  always_ff @(posedge clk) begin
    c_fp_r   <= fprod[2*LOG_FRAC-1:LOG_FRAC];
    c_pl_r   <= TERM_W'(pl_full);
    c_side_r <= it_side_r[LOG_FRAC-1];
    d_ln_r   <= c_pl_r + signed'(TERM_W'(c_fp_r));
    d_side_r <= c_side_r;
  end

  assign out_v  = d_v_r;
  assign ln     = d_ln_r;
  assign side_o = d_side_r;

endmodule

FILE: design/pn_junction_voltage_limiter.sv
// ----------------------------------------------------------------------------
// pn_junction_voltage_limiter
// limits a proposed junction voltage between newton iterations
// ----------------------------------------------------------------------------
// usage
//   input: a transaction is taken at each rising edge with start high and
//   busy low. busy is always low, so one transaction may enter every cycle.
//   new, old voltage signed q16.16; thermal q4.16, critical q15.16 unsigned.
//   output: each result shows on out_limited_voltage and out_limited_flag
//   for exactly one cycle, marked by out_valid. the receiver cannot stall.
//   pipeline: the bit-per-stage divider has VOLT_WIDTH + FRAC_BITS + 1
//   stages and the squaring log pipeline has LOG_FRAC + 4 stages.
//   throughput: one transaction per cycle, results in arrival order.
//   reset: synchronous, active low; clears every valid bit, so no result
//   appears from work in flight. payload registers are not reset.
// flow
//   classify and build the floor clamp, divide, form the log argument,
//   take ln, add the offset, scale by thermal voltage, add to old voltage,
//   saturate. uncompressed items ride along and pick the bypass value.
// ----------------------------------------------------------------------------
module pn_junction_voltage_limiter #(
  parameter int VOLT_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [VOLT_WIDTH-1:0]      in_new_voltage,
  input  logic signed [VOLT_WIDTH-1:0]      in_old_voltage,
  input  logic [pnjl_pkg::VT_W-1:0]         in_thermal_voltage,
  input  logic [pnjl_pkg::VC_W-1:0]         in_critical_voltage,
  output logic                              out_valid,
  output logic signed [VOLT_WIDTH-1:0]      out_limited_voltage,
  output logic                              out_limited_flag
);
  import pnjl_pkg::*;

  localparam int VW  = VOLT_WIDTH;
  localparam int F   = FRAC_BITS;
  // width of delta and its magnitude
  localparam int DW  = VW + 1;
  // dividend and quotient width
  localparam int NW  = DW + F;
  // log argument width
  localparam int XW  = NW + 1;
  // compare width for vn against vc
  localparam int CW  = ((VW > VC_W + 1) ? VW : VC_W + 1) + 1;
  // compare width for |delta| against 2 vt
  localparam int MW  = (DW > VT_W + 1) ? DW : VT_W + 1;
  // floor width
  localparam int FLW = VW + F + 2;
  // product and rounded magnitude widths
  localparam int H   = TERM_W / 2;
  localparam int PW  = VT_W + TERM_W + 1;
  localparam int RW  = PW - LOG_FRAC;
  // final sum width
  localparam int AW  = ((VW > RW + 1) ? VW : RW + 1) + 2;

  localparam logic [FLW-1:0]          ONE_F  = FLW'(1) << F;
  localparam logic signed [FLW-1:0]   FL_LO  = ~FLW'({1'b0, {(VW-1){1'b1}}});
  localparam logic [NW-1:0]           TWO_Q  = NW'(2) << F;
  localparam logic signed [TERM_W-1:0] TWO_L = TERM_W'(2) << LOG_FRAC;
  localparam logic [PW-1:0]           RND    = PW'(1) << (LOG_FRAC - 1);
  localparam logic signed [AW-1:0]    SAT_HI = AW'({1'b0, {(VW-1){1'b1}}});
  localparam logic signed [AW-1:0]    SAT_LO = ~SAT_HI;

  typedef struct packed {
    logic signed [VW-1:0] vo;
    logic [VT_W-1:0]      vt;
    mode_t                mode;
    logic signed [VW-1:0] byp_val;
    logic                 byp_flag;
  } side_t;

  localparam int SW = $bits(side_t);

  // never holds off: every stage moves each cycle
  assign busy = 1'b0;

  // ---------------------------------------------------------------- stage 1
  // delta, critical compare and unsaturated floor
  logic [VT_W-1:0]         vt_fix;
  logic signed [CW-1:0]    vn_c;
  logic signed [CW-1:0]    vc_c;
  logic signed [FLW-1:0]   vo_e;
  logic                    s1_v_r;
  logic signed [VW-1:0]    s1_vn_r;
  logic signed [VW-1:0]    s1_vo_r;
  logic [VT_W-1:0]         s1_vt_r;
  logic signed [DW-1:0]    s1_delta_r;
  logic                    s1_gt_vc_r;
  logic                    s1_vo_pos_r;
  logic signed [FLW-1:0]   s1_floor_r;

  // a zero thermal voltage counts as one lsb
  assign vt_fix = (in_thermal_voltage == '0) ? VT_W'(1) : in_thermal_voltage;
  assign vn_c   = CW'(in_new_voltage);
  assign vc_c   = CW'(in_critical_voltage);
  assign vo_e   = FLW'(in_old_voltage);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    s1_vn_r     <= in_new_voltage;
    s1_vo_r     <= in_old_voltage;
    s1_vt_r     <= vt_fix;
    s1_delta_r  <= DW'(in_new_voltage) - DW'(in_old_voltage);
    s1_gt_vc_r  <= vn_c > vc_c;
    s1_vo_pos_r <= in_old_voltage > 0;
    // floor from the old voltage: mirrored when forward, doubled otherwise
    s1_floor_r  <= (in_old_voltage > 0) ? (-vo_e - signed'(ONE_F))
                                        : ((vo_e <<< 1) - signed'(ONE_F));
  end

  // ---------------------------------------------------------------- stage 2
  // mode select, divider operand, bypass value
  logic [DW-1:0]         adelta;
  logic                  comp;
  mode_t                 mode_nxt;
  logic signed [FLW-1:0] vn_f;
  logic                  clamp;
  side_t                 side_nxt;
  logic                  s2_v_r;
  logic [NW-1:0]         s2_num_r;
  logic [VT_W-1:0]       s2_den_r;
  side_t                 s2_side_r;

  assign adelta = s1_delta_r[DW-1] ? DW'(-s1_delta_r) : s1_delta_r;
  assign comp   = s1_gt_vc_r && (MW'(adelta) > MW'({s1_vt_r, 1'b0}));
  assign vn_f   = FLW'(s1_vn_r);
  // vn below a floor that saturates low can never happen, so compare unsaturated
  assign clamp  = (s1_vn_r < 0) && (vn_f < s1_floor_r);

  always_comb begin
    if (!comp) begin
      mode_nxt = MODE_PASS;
    end else if (!s1_vo_pos_r) begin
      mode_nxt = MODE_ABS;
    end else if (!s1_delta_r[DW-1]) begin
      mode_nxt = MODE_UP;
    end else begin
      mode_nxt = MODE_DOWN;
    end
  end

  always_comb begin
    side_nxt.vo   = s1_vo_r;
    side_nxt.vt   = s1_vt_r;
    side_nxt.mode = mode_nxt;
    if (clamp) begin
      side_nxt.byp_val  = (s1_floor_r < FL_LO) ? VW'(FL_LO) : s1_floor_r[VW-1:0];
      side_nxt.byp_flag = 1'b1;
    end else begin
      side_nxt.byp_val  = s1_vn_r;
      side_nxt.byp_flag = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    // step ratio when the old voltage is forward, else vn over vt
    s2_num_r  <= s1_vo_pos_r ? {adelta, {F{1'b0}}}
                             : {1'b0, s1_vn_r[VW-1:0], {F{1'b0}}};
    s2_den_r  <= s1_vt_r;
    s2_side_r <= side_nxt;
  end

  // ---------------------------------------------------------------- divider
  logic          d_v;
  logic [NW-1:0] d_q;
  logic [SW-1:0] d_side;
  side_t         d_side_s;

  pnjl_div #(
    .NW (NW),
    .SW (SW)
  ) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_v   (s2_v_r),
    .num    (s2_num_r),
    .den    (s2_den_r),
    .side_i (s2_side_r),
    .out_v  (d_v),
    .quo    (d_q),
    .side_o (d_side)
  );

  assign d_side_s = d_side;

  // ---------------------------------------------------------------- stage 3
  // log argument, never zero
  logic [XW-1:0] x_nxt;
  logic          s3_v_r;
  logic [XW-1:0] s3_x_r;
  side_t         s3_side_r;

  always_comb begin
    case (d_side_s.mode)
      MODE_UP:   x_nxt = (d_q > TWO_Q) ? XW'(d_q - TWO_Q) : XW'(1);
      MODE_DOWN: x_nxt = XW'(TWO_Q) + XW'(d_q);
      MODE_ABS:  x_nxt = (d_q == '0) ? XW'(1) : XW'(d_q);
      default:   x_nxt = XW'(1);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else begin
      s3_v_r <= d_v;
    end
  end

  always_ff @(posedge clk) begin
    s3_x_r    <= x_nxt;
    s3_side_r <= d_side_s;
  end

  // ---------------------------------------------------------------- logarithm
  logic                     l_v;
  logic signed [TERM_W-1:0] l_ln;
  logic [SW-1:0]            l_side;
  side_t                    l_side_s;

  pnjl_log #(
    .XW        (XW),
    .FRAC_BITS (F),
    .SW        (SW)
  ) u_log (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_v   (s3_v_r),
    .x      (s3_x_r),
    .side_i (s3_side_r),
    .out_v  (l_v),
    .ln     (l_ln),
    .side_o (l_side)
  );

  assign l_side_s = l_side;

  // ---------------------------------------------------------------- stage 4-5
  // add the offset of two unless in abs mode, then split sign and magnitude
  logic                     s4_v_r;
  logic signed [TERM_W-1:0] s4_term_r;
  side_t                    s4_side_r;
  logic                     s5_v_r;
  logic                     s5_neg_r;
  logic [TERM_W-1:0]        s5_mag_r;
  side_t                    s5_side_r;

  // ---------------------------------------------------------------- stage 6-8
  // vt times magnitude as two partial products, round, apply sign
  logic                     s6_v_r;
  logic                     s6_neg_r;
  logic [VT_W+H-1:0]        s6_lo_r;
  logic [VT_W+TERM_W-H-1:0] s6_hi_r;
  side_t                    s6_side_r;
  logic [PW-1:0]            prod;
  logic                     s7_v_r;
  logic                     s7_neg_r;
  logic [RW-1:0]            s7_r_r;
  side_t                    s7_side_r;
  logic                     sneg;
  logic                     s8_v_r;
  logic signed [RW:0]       s8_sr_r;
  side_t                    s8_side_r;

  assign prod = PW'(s6_lo_r) + (PW'(s6_hi_r) << H) + RND;
  // stepping down subtracts the scaled log, so flip its sign
  assign sneg = s7_neg_r ^ (s7_side_r.mode == MODE_DOWN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
      s6_v_r <= 1'b0;
      s7_v_r <= 1'b0;
      s8_v_r <= 1'b0;
    end else begin
      s4_v_r <= l_v;
      s5_v_r <= s4_v_r;
      s6_v_r <= s5_v_r;
      s7_v_r <= s6_v_r;
      s8_v_r <= s7_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s4_term_r <= (l_side_s.mode == MODE_ABS) ? l_ln : (l_ln + TWO_L);
    s4_side_r <= l_side_s;
    s5_neg_r  <= s4_term_r[TERM_W-1];
    s5_mag_r  <= s4_term_r[TERM_W-1] ? TERM_W'(-s4_term_r) : s4_term_r;
    s5_side_r <= s4_side_r;
    s6_neg_r  <= s5_neg_r;
    s6_lo_r   <= s5_side_r.vt * s5_mag_r[H-1:0];
    s6_hi_r   <= s5_side_r.vt * s5_mag_r[TERM_W-1:H];
    s6_side_r <= s5_side_r;
    s7_neg_r  <= s6_neg_r;
    s7_r_r    <= prod[PW-1:LOG_FRAC];
    s7_side_r <= s6_side_r;
    s8_sr_r   <= sneg ? -signed'({1'b0, s7_r_r}) : signed'({1'b0, s7_r_r});
    s8_side_r <= s7_side_r;
  end

  // ---------------------------------------------------------------- output
  // add to the old voltage (zero in abs mode), saturate, pick bypass for uncompressed items
  logic signed [AW-1:0] base;
  logic signed [AW-1:0] sum;
  logic signed [VW-1:0] sat;
  logic                 out_valid_r;
  logic signed [VW-1:0] out_volt_r;
  logic                 out_flag_r;

  assign base = (s8_side_r.mode == MODE_ABS) ? '0 : AW'(s8_side_r.vo);
  assign sum  = base + AW'(s8_sr_r);

  always_comb begin
    if (sum > SAT_HI) begin
      sat = VW'(SAT_HI);
    end else if (sum < SAT_LO) begin
      sat = VW'(SAT_LO);
    end else begin
      sat = sum[VW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s8_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s8_side_r.mode == MODE_PASS) begin
      out_volt_r <= s8_side_r.byp_val;
      out_flag_r <= s8_side_r.byp_flag;
    end else begin
      out_volt_r <= sat;
      out_flag_r <= 1'b1;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_limited_voltage = out_volt_r;
  assign out_limited_flag    = out_flag_r;

  // ---------------------------------------------------------------- checks
  // the last stage always hands its transaction to the output register
  a_last_stage: assert property (@(posedge clk) disable iff (!rst_n)
    s8_v_r |=> out_valid)
    else $error("stage 8 transaction lost at output");

  // the log argument is never zero
  a_log_arg: assert property (@(posedge clk) disable iff (!rst_n)
    s3_v_r |-> (s3_x_r != '0))
    else $error("zero log argument");

  // a compressed transaction always reports the flag
  a_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_limited_flag) |-> ($past(s8_side_r.mode) == MODE_PASS))
    else $error("compression without flag");

endmodule

FILE: tb/pn_junction_voltage_limiter_tb.sv
// ----------------------------------------------------------------------------
// pn_junction_voltage_limiter_tb
// self-checking bench for the pn-junction voltage limiter
// ----------------------------------------------------------------------------
// each accepted transaction is run through a local bit-exact model of the
// limiter and the expected result is queued; every strobed result is
// compared field by field with the oldest entry. directed corners come
// first, then a random mix of log-compression, clamp and pass-through
// transactions sent in bursts with random gaps
// ----------------------------------------------------------------------------
module pn_junction_voltage_limiter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pnjl_pkg::*;

  localparam int  FRAC       = 16;
  localparam int  CYCLE_CAP  = 400000;
  localparam int  DRAIN_WAIT = 200;
  localparam longint VMAX    = 64'sd2147483647;
  localparam longint VMIN    = -64'sd2147483648;

  typedef struct packed {
    logic signed [31:0] volt;
    logic               flag;
  } limit_res_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic signed [31:0] in_new_voltage = '0;
  logic signed [31:0] in_old_voltage = '0;
  logic [VT_W-1:0]    in_thermal_voltage = 20'd1;
  logic [VC_W-1:0]    in_critical_voltage = '0;
  logic               out_valid;
  logic signed [31:0] out_limited_voltage;
  logic               out_limited_flag;

  limit_res_t expected_q[$];
  int         n_taken = 0;
  int         cycle_cnt = 0;
  int         burst_left = 0;
  bit         failed = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pn_junction_voltage_limiter dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_new_voltage      (in_new_voltage),
    .in_old_voltage      (in_old_voltage),
    .in_thermal_voltage  (in_thermal_voltage),
    .in_critical_voltage (in_critical_voltage),
    .out_valid           (out_valid),
    .out_limited_voltage (out_limited_voltage),
    .out_limited_flag    (out_limited_flag)
  );

  // natural log of x in q16 units, result in q.30, via repeated squaring
  function automatic longint ln_q30(longint unsigned x);
    int               p;
    longint unsigned  m;
    longint unsigned  f;
    p = 63;
    f = 0;
    while (p > 0 && !x[p]) p--;
    if (p > LOG_FRAC) m = x >> (p - LOG_FRAC);
    else m = x << (LOG_FRAC - p);
    for (int i = 0; i < LOG_FRAC; i++) begin
      m = (m * m) >> LOG_FRAC;
      f = f << 1;
      if (m >= (64'd2 << LOG_FRAC)) begin
        m = m >> 1;
        f = f | 64'd1;
      end
    end
    return longint'(p - FRAC) * longint'(LN2_Q30)
         + longint'((f * longint'(LN2_Q30)) >> LOG_FRAC);
  endfunction

  // vt * (offset + ln x), rounded half away from zero back to q16
  function automatic longint vt_times_log(longint unsigned vt, longint unsigned x,
                                          longint offset);
    longint          term;
    longint unsigned mag;
    longint unsigned r;
    term = offset + ln_q30(x);
    mag  = (term < 0) ? longint'(-term) : longint'(term);
    r    = (vt * mag + (64'd1 << (LOG_FRAC - 1))) >> LOG_FRAC;
    return (term < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint clip32(longint v);
    if (v > VMAX) return VMAX;
    if (v < VMIN) return VMIN;
    return v;
  endfunction

  function automatic limit_res_t limit_junction(logic signed [31:0] vn_i,
                                                logic signed [31:0] vo_i,
                                                logic [VT_W-1:0] vt_i,
                                                logic [VC_W-1:0] vc_i);
    longint          vn;
    longint          vo;
    longint unsigned vt;
    longint          vc;
    longint          delta;
    longint unsigned adelta;
    longint unsigned q;
    longint unsigned x;
    longint          res;
    longint          floor_v;
    logic            flag;
    limit_res_t      r;
    vn    = vn_i;
    vo    = vo_i;
    vt    = (vt_i == 0) ? 64'd1 : 64'(vt_i);
    vc    = 64'(vc_i);
    res   = vn;
    flag  = 1'b0;
    delta = vn - vo;
    adelta = (delta < 0) ? longint'(-delta) : longint'(delta);
    if (vn > vc && adelta > 2 * vt) begin
      if (vo > 0) begin
        q = (adelta << FRAC) / vt;
        if (delta > 0) begin
          // a quotient at or below two leaves a log argument of zero
          x = (q > (64'd2 << FRAC)) ? q - (64'd2 << FRAC) : 64'd0;
          if (x == 0) x = 1;
          res = vo + vt_times_log(vt, x, 64'sd2 << LOG_FRAC);
        end else begin
          x = (64'd2 << FRAC) + q;
          res = vo - vt_times_log(vt, x, 64'sd2 << LOG_FRAC);
        end
      end else begin
        x = (longint'(vn) << FRAC) / vt;
        if (x == 0) x = 1;
        res = vt_times_log(vt, x, 0);
      end
      res  = clip32(res);
      flag = 1'b1;
    end else if (vn < 0) begin
      // reverse clamp floor, itself saturated
      floor_v = (vo > 0) ? -vo - (64'sd1 << FRAC) : 2 * vo - (64'sd1 << FRAC);
      floor_v = clip32(floor_v);
      if (vn < floor_v) begin
        res  = floor_v;
        flag = 1'b1;
      end
    end
    r.volt = res[31:0];
    r.flag = flag;
    return r;
  endfunction

  // input side: a transaction is taken when start is high and busy low
  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      expected_q.push_back(limit_junction(in_new_voltage, in_old_voltage,
                                          in_thermal_voltage, in_critical_voltage));
      n_taken <= n_taken + 1;
    end
  end

  // result side: every strobe must match the oldest expectation
  always @(posedge clk) begin
    limit_res_t e;
    if (rst_n && out_valid) begin
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: volt %0d flag %0b",
               out_limited_voltage, out_limited_flag);
        failed = 1'b1;
      end else begin
        e = expected_q.pop_front();
        if (out_limited_voltage !== e.volt) begin
          $error("limited_voltage: expected %0d, got %0d", e.volt, out_limited_voltage);
          failed = 1'b1;
        end
        if (out_limited_flag !== e.flag) begin
          $error("limited_flag: expected %0b, got %0b", e.flag, out_limited_flag);
          failed = 1'b1;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_CAP) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // present one transaction and hold it until taken; start stays high
  task automatic send_item(logic signed [31:0] vn, logic signed [31:0] vo,
                           logic [VT_W-1:0] vt, logic [VC_W-1:0] vc);
    int target;
    in_new_voltage      <= vn;
    in_old_voltage      <= vo;
    in_thermal_voltage  <= vt;
    in_critical_voltage <= vc;
    start               <= 1'b1;
    target = n_taken + 1;
    wait (n_taken >= target);
  endtask

  task automatic idle_cycles(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // bursts of random length with random gaps, some bursts back to back
  task automatic paced_send(logic signed [31:0] vn, logic signed [31:0] vo,
                            logic [VT_W-1:0] vt, logic [VC_W-1:0] vc);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 9));
    end
    burst_left--;
    send_item(vn, vo, vt, vc);
  endtask

  task automatic drain_all();
    idle_cycles(1);
    wait (expected_q.size() == 0);
    @(posedge clk);
  endtask

  task automatic apply_reset();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
  endtask

  // field extremes and named corner cases
  task automatic test_corners();
    send_item(32'sh7fffffff, 32'sh80000000, 20'd1, 31'd0);
    send_item(32'sh80000000, 32'sh7fffffff, 20'd655360, 31'h7fffffff);
    send_item(32'sh80000000, 32'sh80000000, 20'd1, 31'd0);
    send_item(32'sh7fffffff, 32'sh7fffffff, 20'hfffff, 31'h7fffffff);
    // zero thermal voltage treated as one lsb
    send_item(32'sd65536, 32'sd100, 20'd0, 31'd0);
    send_item(32'sh7fffffff, 32'sh80000000, 20'd0, 31'd0);
    // forward compression from a positive old voltage
    send_item(32'sd131072, 32'sd39322, 20'd1700, 31'd39322);
    send_item(32'sh7fffffff, 32'sd1, 20'd1, 31'd0);
    // step just over twice vt: log argument truncates to zero
    send_item(32'sd40000 + 2 * 655360 + 1, 32'sd40000, 20'd655360, 31'd0);
    // backward compression
    send_item(32'sd65536, 32'sh7fff0000, 20'd1700, 31'd0);
    send_item(32'sd2, 32'sh7fffffff, 20'd655360, 31'd1);
    // compression from non-positive old voltage, including a zero quotient
    send_item(32'sd98304, -32'sd65536, 20'd1700, 31'd39322);
    send_item(32'sd1, 32'sh80000000, 20'd655360, 31'd0);
    send_item(32'sh7fffffff, 32'sd0, 20'd1, 31'd0);
    // reverse clamp, positive and non-positive old voltage, and one above the floor
    send_item(-32'sd400000, 32'sd39322, 20'd1700, 31'd39322);
    send_item(-32'sd400000, -32'sd65536, 20'd1700, 31'h7fffffff);
    send_item(-32'sd10, -32'sd65536, 20'd1700, 31'h7fffffff);
    // clamp floor saturates
    send_item(32'sh80000000, 32'sh7fffffff, 20'd1700, 31'h7fffffff);
    send_item(32'sh80000001, 32'sh80000000, 20'd1700, 31'h7fffffff);
    // pass-through with small step
    send_item(32'sd50000, 32'sd49000, 20'd1700, 31'd0);
    send_item(32'sd0, 32'sd0, 20'd1700, 31'd0);
    drain_all();
  endtask

  // random mix weighted towards the limiting paths
  task automatic test_random(int n);
    logic signed [31:0] vn;
    logic signed [31:0] vo;
    logic [VT_W-1:0]    vt;
    logic [VC_W-1:0]    vc;
    for (int i = 0; i < n; i++) begin
      vt = (($urandom_range(0, 3) == 0)) ? 20'($urandom_range(1, 655360))
                                         : 20'($urandom_range(800, 4000));
      vc = 31'($urandom_range(0, 90000));
      case ($urandom_range(0, 6))
        0: begin // forward step of more than twice vt
          vo = 32'sd1 + $signed(32'($urandom_range(0, 200000)));
          vn = vo + 2 * vt + $signed(32'($urandom_range(1, 4000000)));
        end
        1: begin // backward step above vc
          vn = $signed(32'(vc)) + $signed(32'($urandom_range(1, 300000)));
          vo = vn + 2 * vt + $signed(32'($urandom_range(1, 30000000)));
        end
        2: begin // old voltage not positive
          vo = -$signed(32'($urandom_range(0, 2000000)));
          vn = $signed(32'(vc)) + $signed(32'($urandom_range(1, 5000000)));
        end
        3: begin // reverse excursion
          vo = $signed(32'($urandom_range(0, 400000))) - 32'sd200000;
          vn = -$signed(32'($urandom_range(1, 2000000)));
        end
        4: begin // small step, mostly untouched
          vo = $signed(32'($urandom_range(0, 200000))) - 32'sd100000;
          vn = vo + $signed(32'($urandom_range(0, 4 * vt))) - $signed(32'(2 * vt));
        end
        default: begin // unconstrained noise, thermal voltage only up to 655360
          vn = $urandom;
          vo = $urandom;
          vt = 20'($urandom_range(0, 655360));
          vc = 31'($urandom);
        end
      endcase
      paced_send(vn, vo, vt, vc);
      // hold off once mid-run until the pipeline has emptied
      if (i == n / 2) drain_all();
    end
    drain_all();
  endtask

  initial begin
    apply_reset();
    test_corners();
    test_random(600);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (!failed && expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
